FILE: src/min_priority_queue_core_defines.svh
// Assertion macros used by the priority queue core.
`ifndef MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MPQ_ASSERT_NOW(label, ante, cons, msg)
`define MPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: src/mpq_pkg.sv
// Types, codes and constants of the priority queue.
package mpq_pkg;

    localparam int unsigned MPQ_DEPTH = 128;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OCC_W     = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   del;
        entry_t ent;
    } cell_cmd_t;

endpackage

FILE: src/mpq_req_if.sv
// Request channel carrying insert and delete beats.
interface mpq_req_if;
    import mpq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;

    modport source (output valid, output op, output item_value, output item_priority,
                    input ready);
    modport sink (input valid, input op, input item_value, input item_priority,
                  output ready);
endinterface

FILE: src/mpq_rsp_if.sv
// Response channel carrying one result beat per request.
interface mpq_rsp_if;
    import mpq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] out_value;
    logic signed [DATA_W-1:0] out_priority;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output out_value, output out_priority,
                    output occupancy, input ready);
    modport sink (input valid, input status, input out_value, input out_priority,
                  input occupancy, output ready);
endinterface

FILE: src/min_priority_queue_core.sv
// Top level of the priority queue: request and response channels around a cell chain.
// A bounded min priority queue of value/priority pairs, up to DEPTH entries.
// Requests arrive on the req channel: op selects insert or delete, with the
// value and priority to insert. Each request beat gives exactly one response
// beat on the rsp channel with a status, the removed pair on a delete and
// the occupancy after the request, kept to its low eight bits.
// Entries are kept sorted in a chain of cells, lowest priority at the head;
// equal priorities stay in arrival order, so the head is always the entry
// that a delete returns. An insert is broadcast to every cell and the chain
// opens a gap; a delete shifts the whole chain one place up. A request's
// response is registered and is valid in the cycle after the request is taken.
// One request per cycle is sustained while the receiver takes responses; the
// single response register sets that figure.
// If the receiver stalls, the response is held and req.ready stays low until
// it is taken. Reset empties the queue and the response register; no
// clearing pass is needed because only occupied cells are ever read.
`include "min_priority_queue_core_defines.svh"

module min_priority_queue_core #(
    parameter int unsigned DEPTH = mpq_pkg::MPQ_DEPTH
) (
    input logic   clk,
    input logic   rst_n,
    mpq_req_if.sink   req,
    mpq_rsp_if.source rsp
);
    import mpq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic signed [DATA_W-1:0] prio_reg;
    logic signed [DATA_W-1:0] prio_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;

    logic      accept;
    logic      do_ins;
    logic      do_del;
    cell_cmd_t cmd;
    entry_t    chain_ent [DEPTH+1];
    logic [DEPTH:0] keep_vec;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign do_ins    = accept && (req.op == OP_INSERT) && (count_reg != FULL_C);
    assign do_del    = accept && (req.op == OP_DELETE) && (count_reg != '0);

    assign cmd.ins       = do_ins;
    assign cmd.del       = do_del;
    assign cmd.ent.value = req.item_value;
    assign cmd.ent.prio  = req.item_priority;

    assign keep_vec[0]      = 1'b1;
    assign chain_ent[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            mpq_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .prev_keep (keep_vec[i]),
                .prev_ent  (cmd.ent),
                .next_ent  (chain_ent[i+1]),
                .ent       (chain_ent[i]),
                .keep      (keep_vec[i+1])
            );
        end
        else
        begin : g_body
            mpq_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .prev_keep (keep_vec[i]),
                .prev_ent  (chain_ent[i-1]),
                .next_ent  (chain_ent[i+1]),
                .ent       (chain_ent[i]),
                .keep      (keep_vec[i+1])
            );
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        status_next = status_reg;
        value_next  = value_reg;
        prio_next   = prio_reg;
        occ_next    = occ_reg;
        if (accept)
        begin
            value_next = '0;
            prio_next  = '0;
            occ_next   = OCC_W'({{OCC_W{1'b0}}, count_next});
            case (req.op)
                OP_INSERT:
                begin
                    status_next = do_ins ? ST_INSERTED : ST_OVERFLOW;
                end
                OP_DELETE:
                begin
                    status_next = do_del ? ST_DELETED : ST_UNDERFLOW;
                    if (do_del)
                    begin
                        value_next = chain_ent[0].value;
                        prio_next  = chain_ent[0].prio;
                    end
                end
                default:
                begin
                    status_next = ST_UNDERFLOW;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        prio_reg   <= prio_next;
        occ_reg    <= occ_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_value    = value_reg;
    assign rsp.out_priority = prio_reg;
    assign rsp.occupancy    = occ_reg;

    `MPQ_ASSERT_NEXT(a_ins_count, do_ins, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow the queue")
    `MPQ_ASSERT_NEXT(a_del_count, do_del, count_reg == $past(count_reg) - CNT_W'(1), "delete did not shrink the queue")
    `MPQ_ASSERT_NEXT(a_rsp_after_req, accept, rsp.valid, "request beat gave no response beat")
    `MPQ_ASSERT_NOW(a_head_sorted, count_reg > CNT_W'(1), !($signed(chain_ent[1].prio) < $signed(chain_ent[0].prio)), "head is not the lowest priority")
    `MPQ_ASSERT_NOW(a_tail_free, do_ins, !keep_vec[DEPTH], "insert found the tail cell in use")

endmodule

FILE: src/mpq_cell.sv
// One cell of the sorted chain: holds an entry and shifts or takes a new one.
module mpq_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 8
) (
    input  logic               clk,
    input  mpq_pkg::cell_cmd_t cmd,
    input  logic [CNT_W-1:0]   count,
    input  logic               prev_keep,
    input  mpq_pkg::entry_t    prev_ent,
    input  mpq_pkg::entry_t    next_ent,
    output mpq_pkg::entry_t    ent,
    output logic               keep
);
    import mpq_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    entry_t data_reg;
    entry_t data_next;
    logic   occupied;

    // An occupied cell whose priority is not above the new one keeps its entry.
    assign occupied = (count > IDX_C);
    assign keep     = occupied && !($signed(cmd.ent.prio) < $signed(data_reg.prio));
    assign ent      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    data_next = cmd.ent;
                end
                else
                begin
                    data_next = prev_ent;
                end
            end
        end
        else if (cmd.del)
        begin
            data_next = next_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
